// File: rtl/two_channel_block_averager_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-channel block averager
// Clocked on i_clk, checks disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_BLOCK_AVERAGER_MACROS_SVH
`define TWO_CHANNEL_BLOCK_AVERAGER_MACROS_SVH

// Same-cycle implication.
`define BAVG_ASSERT_NOW(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BAVG_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// File: rtl/bavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and types of the two-channel block averager.
// ----------------------------------------------------------------------------
package bavg_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int WINDOW_LEN = 16;   // samples per window, 4..256
    localparam int AVG_SHIFT  = 4;    // average = sum >> AVG_SHIFT, 2..8
    localparam int SETTLE_LEN = 2;    // unsummed samples per window

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = $clog2((WINDOW_LEN - SETTLE_LEN) * ((1 << SAMPLE_W) - 1) + 1);

    localparam logic [SAMPLE_W-1:0] AVG_MAX = {SAMPLE_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [SUM_W-1:0]    t_sum;

    typedef struct packed {
        logic    next_channel;
        logic    window_done;
        logic    done_channel;
        t_sample average_ch0;
        t_sample average_ch1;
        t_sample peak_max;
        t_sample peak_min;
    } t_result;

endpackage

// File: rtl/bavg_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_in_stage
// Input request register; holds one sample until the core takes it.
// ----------------------------------------------------------------------------
module bavg_in_stage
    import bavg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sample i_sample,
    input  logic    i_advance,
    output logic    o_stall,
    output logic    o_valid,
    output t_sample o_sample
);

    logic    r_valid;
    logic    n_valid;
    t_sample r_sample;
    logic    w_load;

    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;
    assign n_valid = w_load ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// File: rtl/bavg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_core
// Window counter, per-channel sums, averages and running extremes.
// ----------------------------------------------------------------------------
module bavg_core
    import bavg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_sample i_sample,
    output t_result o_result
);

`include "two_channel_block_averager_macros.svh"

    t_count  r_count, n_count;
    logic    r_active, n_active;
    t_sum    r_sum0, n_sum0;
    t_sum    r_sum1, n_sum1;
    t_sample r_avg0, n_avg0;
    t_sample r_avg1, n_avg1;
    t_sample r_max, n_max;
    t_sample r_min, n_min;

    logic [CNT_W:0] w_pos_inc;
    logic           w_close;
    t_sum           w_shifted;
    t_sample        w_avg;

    always_comb begin
        w_pos_inc = {1'b0, r_count} + (CNT_W + 1)'(1);
        w_close   = w_pos_inc >= (CNT_W + 1)'(WINDOW_LEN);
        n_count   = w_close ? '0 : w_pos_inc[CNT_W-1:0];
        n_active  = w_close ? !r_active : r_active;

        // closing average of the channel being summed, saturated
        w_shifted = (r_active ? r_sum1 : r_sum0) >> AVG_SHIFT;
        w_avg     = (w_shifted > SUM_W'(AVG_MAX)) ? AVG_MAX : w_shifted[SAMPLE_W-1:0];

        n_sum0 = r_sum0;
        n_sum1 = r_sum1;
        n_avg0 = r_avg0;
        n_avg1 = r_avg1;
        n_max  = r_max;
        n_min  = r_min;

        if (w_close) begin
            if (r_active) begin
                n_avg1 = w_avg;
                n_sum1 = '0;
            end else begin
                n_avg0 = w_avg;
                n_sum0 = '0;
            end
            if (w_avg > r_max) begin
                n_max = w_avg;
            end
            if (w_avg < r_min) begin
                n_min = w_avg;
            end
        end else if (n_count >= CNT_W'(SETTLE_LEN)) begin
            if (r_active) begin
                n_sum1 = r_sum1 + SUM_W'(i_sample);
            end else begin
                n_sum0 = r_sum0 + SUM_W'(i_sample);
            end
        end

        o_result.next_channel = n_active;
        o_result.window_done  = w_close;
        o_result.done_channel = w_close && r_active;
        o_result.average_ch0  = n_avg0;
        o_result.average_ch1  = n_avg1;
        o_result.peak_max     = n_max;
        o_result.peak_min     = n_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= 1'b0;
            r_sum0   <= '0;
            r_sum1   <= '0;
            r_avg0   <= '0;
            r_avg1   <= '0;
            r_max    <= '0;
            r_min    <= AVG_MAX;
        end else if (i_fire) begin
            r_count  <= n_count;
            r_active <= n_active;
            r_sum0   <= n_sum0;
            r_sum1   <= n_sum1;
            r_avg0   <= n_avg0;
            r_avg1   <= n_avg1;
            r_max    <= n_max;
            r_min    <= n_min;
        end
    end

    `BAVG_ASSERT_NEXT(a_close_wraps, i_fire && w_close, r_count == '0, "window did not wrap")
    `BAVG_ASSERT_NEXT(a_toggle_on_close, i_fire, (r_active != $past(r_active)) == $past(w_close), "channel toggle mismatch")
    `BAVG_ASSERT_NEXT(a_sum_cleared, i_fire && w_close, (($past(r_active) ? r_sum1 : r_sum0) == '0), "closed sum not cleared")
    `BAVG_ASSERT_NOW(a_done_on_wrap, i_fire && w_close, r_count == t_count'(WINDOW_LEN - 1), "close at wrong position")

endmodule

// File: rtl/bavg_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bavg_out_stage
// Result register; advances whenever it is empty or the request is taken.
// ----------------------------------------------------------------------------
module bavg_out_stage
    import bavg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;
    assign n_valid   = o_advance ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/two_channel_block_averager.sv
// Path: an accepted sample passes the input register, then the result
// register; i_stall can hold it in either one.
// Throughput: one sample per cycle unless i_stall holds a full result
// register; per sample the core does a count add, a sum add and compares.
// Reset: synchronous, active low; averages and max clear to 0, min to 1023.
// ----------------------------------------------------------------------------
// two_channel_block_averager
// Block-average decimator alternating between two converter channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module two_channel_block_averager
    import bavg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    // sample request
    input  logic    i_valid,
    output logic    o_stall,
    input  t_sample i_sample,
    // result request
    output logic    o_valid,
    input  logic    i_stall,
    output logic    o_next_channel,
    output logic    o_window_done,
    output logic    o_done_channel,
    output t_sample o_average_ch0,
    output t_sample o_average_ch1,
    output t_sample o_peak_max,
    output t_sample o_peak_min
);

    // Pipeline: in_stage -> core (state update on fire) -> out_stage.
    // The core's state moves exactly when an item passes from the input
    // register into the result register, so stalls never repeat or drop
    // a state update.

    logic    w_s1_valid;
    t_sample w_s1_sample;
    logic    w_advance;
    logic    w_fire;
    t_result w_core_result;
    t_result w_out_result;

    bavg_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .i_advance (w_advance),
        .o_stall   (o_stall),
        .o_valid   (w_s1_valid),
        .o_sample  (w_s1_sample)
    );

    // an item moves on when it exists and the result register is free
    assign w_fire = w_s1_valid && w_advance;

    bavg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_sample (w_s1_sample),
        .o_result (w_core_result)
    );

    bavg_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s1_valid),
        .i_result  (w_core_result),
        .i_stall   (i_stall),
        .o_advance (w_advance),
        .o_valid   (o_valid),
        .o_result  (w_out_result)
    );

    assign o_next_channel = w_out_result.next_channel;
    assign o_window_done  = w_out_result.window_done;
    assign o_done_channel = w_out_result.done_channel;
    assign o_average_ch0  = w_out_result.average_ch0;
    assign o_average_ch1  = w_out_result.average_ch1;
    assign o_peak_max     = w_out_result.peak_max;
    assign o_peak_min     = w_out_result.peak_min;

endmodule
